[sv/assert_macros.svh]
// shared assertion macros, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PIPW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition must never be seen
`define PIPW_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

[sv/pipw_pkg.sv]
package pipw_pkg;

    localparam int MAX_SPLIT_DEPTH_DEF = 10;
    localparam int FRAC_BITS_DEF       = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE = 3'd4;

    localparam logic [1:0] ACT_MOVE  = 2'd0;
    localparam logic [1:0] ACT_LINE  = 2'd1;
    localparam logic [1:0] ACT_CUBIC = 2'd2;
    localparam logic [1:0] ACT_SKIP  = 2'd3;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MOVE,
        OP_LINE,
        OP_CURVE
    } op_t;

    typedef struct packed {
        op_t    op;
        logic   pre_close;
        logic   post_close;
        logic   last;
        point_t pt;
        point_t c1;
        point_t c2;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic [30:0]        eps;
        logic [61:0]        tol;
        logic               fill;
    } cfg_t;

    typedef struct packed {
        logic hit;
        logic up;
        logic down;
    } edge_res_t;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

endpackage

[sv/pipw_ram.sv]
module pipw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/pipw_edge.sv]
module pipw_edge #(
    parameter int FRAC_BITS = pipw_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  pipw_pkg::point_t      a,
    input  pipw_pkg::point_t      b,
    input  pipw_pkg::cfg_t        cfg,
    output logic                  done,
    output pipw_pkg::edge_res_t   res
);
    import pipw_pkg::*;

    typedef struct packed {
        logic dir_neg;
        logic hit_end;
        logic rng;
        logic cross_ok;
        logic both_le;
    } flags_t;

    logic   v1_reg, v2_reg, done_reg;
    flags_t f1_next, f1_reg, f2_reg;
    point_t p1, p2;
    logic   swap;

    logic signed [32:0] adx_next, dx_next, dy1_next, dy2_next;
    logic signed [32:0] adx_reg, dx_reg, dy1_reg, dy2_reg;

    logic signed [33:0] adx34, dx34, abs_adx, eps34, sv;
    logic               near_vert, wrong_side;
    logic               pre_pos_next, pre_neg_next, mode_next;
    logic               pre_pos_reg, pre_neg_reg, mode_reg;
    logic signed [65:0] m1_next, m2_next, m1_reg, m2_reg;

    logic signed [66:0] cross_v, e67;
    logic               pos, neg, hit, crossing;
    edge_res_t          res_next, res_reg;

    // stage 1: order by y, range tests and differences
    assign swap = b.y < a.y;
    assign p1   = swap ? b : a;
    assign p2   = swap ? a : b;

    always_comb
    begin
        f1_next.dir_neg  = swap;
        f1_next.hit_end  = (p1.x == cfg.qx && p1.y == cfg.qy) ||
                           (p2.x == cfg.qx && p2.y == cfg.qy);
        f1_next.rng      = !(p2.y < cfg.qy || p1.y > cfg.qy ||
                             (p1.x > cfg.qx && p2.x > cfg.qx) ||
                             (p1.x < cfg.qx && p2.x < cfg.qx));
        f1_next.cross_ok = (p2.y > cfg.qy) && (p1.y <= cfg.qy) &&
                           !(p1.x >= cfg.qx && p2.x >= cfg.qx);
        f1_next.both_le  = (p1.x <= cfg.qx) && (p2.x <= cfg.qx);
        adx_next = sx33(p2.x) - sx33(p1.x);
        dx_next  = sx33(cfg.qx) - sx33(p1.x);
        dy1_next = sx33(cfg.qy) - sx33(p1.y);
        dy2_next = sx33(p2.y) - sx33(p1.y);
    end

    // stage 2: short-cut side cases and the two cross products
    assign adx34      = {adx_reg[32], adx_reg};
    assign dx34       = {dx_reg[32], dx_reg};
    assign abs_adx    = adx34[33] ? -adx34 : adx34;
    assign eps34      = $signed({3'b000, cfg.eps});
    assign near_vert  = abs_adx < eps34;
    assign wrong_side = (adx_reg > 0 && dx_reg < 0) || (adx_reg < 0 && dx_reg >= 0);
    assign sv         = near_vert ? -dx34 : adx34;
    assign pre_pos_next = sv > eps34;
    assign pre_neg_next = sv < -eps34;
    assign mode_next    = !near_vert && !wrong_side;
    assign m1_next      = dy1_reg * adx_reg;
    assign m2_next      = dx_reg * dy2_reg;

    // stage 3: tolerance compare and verdict
    assign cross_v  = m1_reg - m2_reg;
    assign e67      = $signed({36'd0, cfg.eps} << FRAC_BITS);
    assign pos      = mode_reg ? (cross_v > e67) : pre_pos_reg;
    assign neg      = mode_reg ? (cross_v < -e67) : pre_neg_reg;
    assign hit      = f2_reg.hit_end || (f2_reg.rng && !pos && !neg);
    assign crossing = !hit && f2_reg.cross_ok && (f2_reg.both_le || neg);

    always_comb
    begin
        res_next.hit  = hit;
        res_next.up   = crossing && !f2_reg.dir_neg;
        res_next.down = crossing && f2_reg.dir_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg      <= f1_next;
        adx_reg     <= adx_next;
        dx_reg      <= dx_next;
        dy1_reg     <= dy1_next;
        dy2_reg     <= dy2_next;
        f2_reg      <= f1_reg;
        pre_pos_reg <= pre_pos_next;
        pre_neg_reg <= pre_neg_next;
        mode_reg    <= mode_next;
        m1_reg      <= m1_next;
        m2_reg      <= m2_next;
        res_reg     <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

[sv/pipw_front.sv]
module pipw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic [1:0]         action,
    input  logic               close_subpath,
    input  logic               last_point,
    output logic               cmd_valid,
    input  logic               cmd_pop,
    output pipw_pkg::cmd_t     cmd
);
    import pipw_pkg::*;

    localparam int QD = 2;

    cmd_t       q_reg [QD];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    point_t     ctrl_reg [2];
    logic [1:0] pcount_reg, pcount_next;
    logic [1:0] pclose_reg, pclose_next;
    logic       ctrl_we;

    logic       accept, emit, wr, rd;
    cmd_t       new_cmd;

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // turn points into commands; controls wait here until their end point comes
    always_comb
    begin
        emit               = 1'b0;
        ctrl_we            = 1'b0;
        pcount_next        = pcount_reg;
        pclose_next        = pclose_reg;
        new_cmd.op         = OP_NOP;
        new_cmd.pre_close  = 1'b0;
        new_cmd.post_close = close_subpath;
        new_cmd.last       = last_point;
        new_cmd.pt         = {point_x, point_y};
        new_cmd.c1         = ctrl_reg[0];
        new_cmd.c2         = ctrl_reg[1];
        if (action == ACT_CUBIC)
        begin
            if (pcount_reg == 2'd2)
            begin
                emit        = 1'b1;
                new_cmd.op  = OP_CURVE;
                pcount_next = 2'd0;
                pclose_next = 2'd0;
            end
            else
            begin
                ctrl_we     = 1'b1;
                pclose_next = pclose_reg | ({1'b0, close_subpath} << pcount_reg[0]);
                pcount_next = pcount_reg + 2'd1;
                if (last_point)
                begin
                    // leftover controls dropped, their closes still apply
                    emit               = 1'b1;
                    new_cmd.post_close = |pclose_next;
                    pcount_next        = 2'd0;
                    pclose_next        = 2'd0;
                end
            end
        end
        else
        begin
            emit              = 1'b1;
            new_cmd.pre_close = |pclose_reg;
            pcount_next       = 2'd0;
            pclose_next       = 2'd0;
            case (action)
                ACT_MOVE: new_cmd.op = OP_MOVE;
                ACT_LINE: new_cmd.op = OP_LINE;
                default:  new_cmd.op = OP_NOP;
            endcase
        end
    end

    assign wr = accept && emit;
    assign rd = cmd_pop && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            pcount_reg <= 2'd0;
            pclose_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (accept)
            begin
                pcount_reg <= pcount_next;
                pclose_reg <= pclose_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
        if (accept && ctrl_we)
        begin
            ctrl_reg[pcount_reg[0]] <= {point_x, point_y};
        end
    end

endmodule

[sv/pipw_back.sv]
`include "assert_macros.svh"

module pipw_back #(
    parameter int MAX_SPLIT_DEPTH = pipw_pkg::MAX_SPLIT_DEPTH_DEF,
    parameter int FRAC_BITS       = pipw_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  pipw_pkg::cmd_t     cmd,
    input  pipw_pkg::cfg_t     cfg,
    output logic               empty,
    input  logic               pop,
    output logic               inside_res,
    output logic               on_edge,
    output logic signed [15:0] winding
);
    import pipw_pkg::*;

    localparam int DW = $clog2(MAX_SPLIT_DEPTH + 1);
    localparam int AW = (MAX_SPLIT_DEPTH > 1) ? $clog2(MAX_SPLIT_DEPTH) : 1;
    localparam logic [DW-1:0] DEPTH_LIM = DW'(MAX_SPLIT_DEPTH);
    localparam logic signed [15:0] WIND_MAX = 16'sh7FFF;
    localparam logic signed [15:0] WIND_MIN = -16'sh8000;

    typedef struct packed {
        point_t        a;
        point_t        b;
        point_t        c;
        point_t        d;
        logic [DW-1:0] depth;
    } piece_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_OP,
        S_LEN,
        S_CMP,
        S_NEXT,
        S_POP,
        S_EWAIT,
        S_POST,
        S_FIN
    } state_t;

    state_t             state_reg, state_next, ret_reg, ret_next;
    cmd_t               cmd_reg, cmd_next;
    point_t             cur_reg, cur_next, start_reg, start_next;
    logic               have_reg, have_next, hit_reg, hit_next;
    logic signed [15:0] wind_reg, wind_next;
    piece_t             piece_reg, piece_next;
    logic [DW-1:0]      sp_reg, sp_next, sp_dec;
    logic [65:0]        sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic               out_valid_reg, out_valid_next;
    logic               res_inside_reg, res_inside_next, res_edge_reg, res_edge_next;
    logic signed [15:0] res_wind_reg, res_wind_next;

    logic               edge_start, edge_done;
    point_t             edge_a, edge_b;
    edge_res_t          edge_res;

    logic               ram_we;
    piece_t             ram_wdata, ram_rdata;

    logic signed [32:0] ddx, ddy;
    logic signed [65:0] prx, pry;
    logic [66:0]        len;
    logic               flat, reject, tangent0;
    point_t             ab, bc, cd, abc, bcd, mm;

    function automatic logic signed [31:0] mid32(input logic signed [31:0] u,
                                                 input logic signed [31:0] v);
        logic signed [32:0] s;
        s = sx33(u) + sx33(v);
        return s[32:1];
    endfunction

    function automatic point_t mid_pt(input point_t u, input point_t v);
        point_t r;
        r.x = mid32(u.x, v.x);
        r.y = mid32(u.y, v.y);
        return r;
    endfunction

    pipw_edge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (edge_start),
        .a     (edge_a),
        .b     (edge_b),
        .cfg   (cfg),
        .done  (edge_done),
        .res   (edge_res)
    );

    // pending second halves of split curves
    pipw_ram #(
        .WIDTH ($bits(piece_t)),
        .DEPTH (MAX_SPLIT_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sp_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (sp_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign sp_dec = sp_reg - 1'b1;

    assign ddx = sx33(piece_reg.d.x) - sx33(piece_reg.a.x);
    assign ddy = sx33(piece_reg.d.y) - sx33(piece_reg.a.y);
    assign prx = ddx * ddx;
    assign pry = ddy * ddy;
    assign len = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign flat = (len <= {5'd0, cfg.tol}) || (piece_reg.depth >= DEPTH_LIM);

    assign ab  = mid_pt(piece_reg.a, piece_reg.b);
    assign bc  = mid_pt(piece_reg.b, piece_reg.c);
    assign cd  = mid_pt(piece_reg.c, piece_reg.d);
    assign abc = mid_pt(ab, bc);
    assign bcd = mid_pt(bc, cd);
    assign mm  = mid_pt(abc, bcd);

    // control box lies wholly above, below or right of the query point
    assign reject =
        (cur_reg.y < cfg.qy && cmd_reg.c1.y < cfg.qy &&
         cmd_reg.c2.y < cfg.qy && cmd_reg.pt.y < cfg.qy) ||
        (cur_reg.y > cfg.qy && cmd_reg.c1.y > cfg.qy &&
         cmd_reg.c2.y > cfg.qy && cmd_reg.pt.y > cfg.qy) ||
        (cur_reg.x > cfg.qx && cmd_reg.c1.x > cfg.qx &&
         cmd_reg.c2.x > cfg.qx && cmd_reg.pt.x > cfg.qx);
    assign tangent0 = (cur_reg == cmd_reg.c1) && (cmd_reg.c2 == cmd_reg.pt);

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cmd_next        = cmd_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        have_next       = have_reg;
        hit_next        = hit_reg;
        wind_next       = wind_reg;
        piece_next      = piece_reg;
        sp_next         = sp_reg;
        sqx_next        = sqx_reg;
        sqy_next        = sqy_reg;
        out_valid_next  = out_valid_reg;
        res_inside_next = res_inside_reg;
        res_edge_next   = res_edge_reg;
        res_wind_next   = res_wind_reg;
        cmd_pop         = 1'b0;
        edge_start      = 1'b0;
        edge_a          = cur_reg;
        edge_b          = start_reg;
        ram_we          = 1'b0;
        ram_wdata       = '{a: mm, b: bcd, c: cd, d: piece_reg.d,
                            depth: piece_reg.depth + 1'b1};

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    cmd_pop    = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                state_next = S_OP;
                if (cmd_reg.pre_close && have_reg)
                begin
                    have_next  = 1'b0;
                    edge_start = !hit_reg;
                    ret_next   = S_OP;
                    state_next = hit_reg ? S_OP : S_EWAIT;
                end
            end
            S_OP:
            begin
                state_next = S_POST;
                ret_next   = S_POST;
                case (cmd_reg.op)
                    OP_MOVE:
                    begin
                        edge_start = have_reg && !hit_reg;
                        start_next = cmd_reg.pt;
                        cur_next   = cmd_reg.pt;
                        have_next  = 1'b1;
                        if (have_reg && !hit_reg)
                        begin
                            state_next = S_EWAIT;
                        end
                    end
                    OP_LINE:
                    begin
                        edge_b     = cmd_reg.pt;
                        edge_start = have_reg && !hit_reg;
                        cur_next   = cmd_reg.pt;
                        have_next  = 1'b1;
                        if (have_reg && !hit_reg)
                        begin
                            state_next = S_EWAIT;
                        end
                    end
                    OP_CURVE:
                    begin
                        if (reject)
                        begin
                            cur_next = cmd_reg.pt;
                        end
                        else if (tangent0)
                        begin
                            edge_b     = cmd_reg.pt;
                            edge_start = have_reg && !hit_reg;
                            cur_next   = cmd_reg.pt;
                            have_next  = 1'b1;
                            if (have_reg && !hit_reg)
                            begin
                                state_next = S_EWAIT;
                            end
                        end
                        else
                        begin
                            piece_next = '{a: cur_reg, b: cmd_reg.c1, c: cmd_reg.c2,
                                           d: cmd_reg.pt, depth: '0};
                            sp_next    = '0;
                            state_next = S_LEN;
                        end
                    end
                    default:
                    begin
                        state_next = S_POST;
                    end
                endcase
            end
            S_LEN:
            begin
                sqx_next   = $unsigned(prx);
                sqy_next   = $unsigned(pry);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (flat)
                begin
                    edge_b     = piece_reg.d;
                    edge_start = have_reg && !hit_reg;
                    cur_next   = piece_reg.d;
                    have_next  = 1'b1;
                    ret_next   = S_NEXT;
                    state_next = (have_reg && !hit_reg) ? S_EWAIT : S_NEXT;
                end
                else
                begin
                    // second half parked on the stack, first half goes on
                    ram_we     = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    piece_next = '{a: piece_reg.a, b: ab, c: abc, d: mm,
                                   depth: piece_reg.depth + 1'b1};
                    state_next = S_LEN;
                end
            end
            S_NEXT:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    sp_next    = sp_dec;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                piece_next = ram_rdata;
                state_next = S_LEN;
            end
            S_EWAIT:
            begin
                if (edge_done)
                begin
                    state_next = ret_reg;
                    if (edge_res.hit)
                    begin
                        hit_next = 1'b1;
                    end
                    else if (edge_res.up && wind_reg != WIND_MAX)
                    begin
                        wind_next = wind_reg + 16'sd1;
                    end
                    else if (edge_res.down && wind_reg != WIND_MIN)
                    begin
                        wind_next = wind_reg - 16'sd1;
                    end
                end
            end
            S_POST:
            begin
                state_next = S_FIN;
                if (cmd_reg.post_close && have_reg)
                begin
                    have_next  = 1'b0;
                    edge_start = !hit_reg;
                    ret_next   = S_FIN;
                    state_next = hit_reg ? S_FIN : S_EWAIT;
                end
            end
            S_FIN:
            begin
                if (!cmd_reg.last)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    res_inside_next = hit_reg ||
                                      (cfg.fill ? wind_reg[0] : (wind_reg != 16'sd0));
                    res_edge_next   = hit_reg;
                    res_wind_next   = wind_reg;
                    hit_next        = 1'b0;
                    wind_next       = 16'sd0;
                    start_next      = '0;
                    cur_next        = '0;
                    have_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            cmd_reg        <= '0;
            cur_reg        <= '0;
            start_reg      <= '0;
            have_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            wind_reg       <= 16'sd0;
            piece_reg      <= '0;
            sp_reg         <= '0;
            sqx_reg        <= '0;
            sqy_reg        <= '0;
            out_valid_reg  <= 1'b0;
            res_inside_reg <= 1'b0;
            res_edge_reg   <= 1'b0;
            res_wind_reg   <= 16'sd0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cmd_reg        <= cmd_next;
            cur_reg        <= cur_next;
            start_reg      <= start_next;
            have_reg       <= have_next;
            hit_reg        <= hit_next;
            wind_reg       <= wind_next;
            piece_reg      <= piece_next;
            sp_reg         <= sp_next;
            sqx_reg        <= sqx_next;
            sqy_reg        <= sqy_next;
            out_valid_reg  <= out_valid_next;
            res_inside_reg <= res_inside_next;
            res_edge_reg   <= res_edge_next;
            res_wind_reg   <= res_wind_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign inside_res = res_inside_reg;
    assign on_edge    = res_edge_reg;
    assign winding    = res_wind_reg;

    `PIPW_ASSERT_NEVER(a_stack_bound, sp_reg > DEPTH_LIM)
    `PIPW_ASSERT_IMP(a_edge_waited, edge_done, state_reg == S_EWAIT)
    `PIPW_ASSERT_IMP(a_result_from_fin, $rose(out_valid_reg), $past(state_reg == S_FIN))

endmodule

[sv/point_in_path_winding_test.sv]
// point-in-path test by winding number over a streamed path
// input words (point_x, point_y, action, close_subpath, last_point) go in
// with push while full is low; each becomes a command in a two-word queue,
// and cubic controls are held in the front until their end point arrives
// the back pulls one command at a time: a line or move with an edge goes
// through pick-up, pre-close check, issue, edge unit, close check, finish;
// each close edge adds an edge unit pass; a curve adds length and compare
// steps per piece visited and, per flat piece, the edge, a stack check and
// a pop if one is parked; at most 2^(MAX_SPLIT_DEPTH+1)-1 pieces
// one result word (inside_res, on_edge, winding) follows the word marked
// last_point; it sits on the outputs while empty is low and leaves with pop
// while it waits the back holds at its final step, the queue fills and
// full rises; input words never get lost
// the config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready and should be written only while the block is idle
// reset sets query point 0, tolerance 1, flatness 1, nonzero rule, and an
// empty path with no result waiting
module point_in_path_winding_test #(
    parameter int MAX_SPLIT_DEPTH = pipw_pkg::MAX_SPLIT_DEPTH_DEF,
    parameter int FRAC_BITS       = pipw_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic [1:0]                       action,
    input  logic                             close_subpath,
    input  logic                             last_point,
    output logic                             empty,
    input  logic                             pop,
    output logic                             inside_res,
    output logic                             on_edge,
    output logic signed [15:0]               winding,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pipw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data
);
    import pipw_pkg::*;

    cfg_t cfg_reg;
    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qx   <= 32'sd0;
            cfg_reg.qy   <= 32'sd0;
            cfg_reg.eps  <= 31'd1;
            cfg_reg.tol  <= 62'd1;
            cfg_reg.fill <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_QUERY_X:   cfg_reg.qx   <= cfg_data[31:0];
                CFG_QUERY_Y:   cfg_reg.qy   <= cfg_data[31:0];
                CFG_EPSILON:   cfg_reg.eps  <= cfg_data[30:0];
                CFG_FLAT_TOL:  cfg_reg.tol  <= cfg_data[61:0];
                CFG_FILL_MODE: cfg_reg.fill <= cfg_data[0];
                default:       cfg_reg      <= cfg_reg;
            endcase
        end
    end

    pipw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .point_x       (point_x),
        .point_y       (point_y),
        .action        (action),
        .close_subpath (close_subpath),
        .last_point    (last_point),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd)
    );

    pipw_back #(
        .MAX_SPLIT_DEPTH (MAX_SPLIT_DEPTH),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .empty      (empty),
        .pop        (pop),
        .inside_res (inside_res),
        .on_edge    (on_edge),
        .winding    (winding)
    );

endmodule
